/* rtl/core/urs_pkg.sv */
// Shared types and codes for the undo/redo stack pair.
package urs_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_RECORD = 2'd0;
    localparam mode_t MODE_UNDO   = 2'd1;
    localparam mode_t MODE_REDO   = 2'd2;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 8;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;  // latch input word, read both stack tops
        logic exec;  // apply the operation and load the result register
    } urs_cmd_t;

endpackage

/* rtl/core/urs_ctrl.sv */
// Sequencer: accept, execute, and result-valid handshake.
module urs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output urs_pkg::urs_cmd_t cmd
);
    import urs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/core/urs_dpath.sv */
// Stack memories, depth counters and result register.
module urs_dpath #(
    parameter int STACK_DEPTH = 128,
    parameter int TOKEN_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  urs_pkg::urs_cmd_t             cmd,
    input  urs_pkg::mode_t                in_mode,
    input  logic [urs_pkg::VALUE_W-1:0]   in_value,
    output urs_pkg::status_t              out_status,
    output logic [urs_pkg::VALUE_W-1:0]   out_value,
    output logic [urs_pkg::DEPTH_W-1:0]   out_undo_depth,
    output logic [urs_pkg::DEPTH_W-1:0]   out_redo_depth
);
    import urs_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int TW_W   = (TOKEN_WIDTH > VALUE_W) ? TOKEN_WIDTH : VALUE_W;
    localparam int CW_W   = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [TOKEN_WIDTH-1:0] undo_mem [STACK_DEPTH];
    logic [TOKEN_WIDTH-1:0] redo_mem [STACK_DEPTH];

    mode_t                  mode_reg;
    logic [TOKEN_WIDTH-1:0] value_reg;
    logic [TOKEN_WIDTH-1:0] undo_rd_reg, redo_rd_reg;
    logic [CNT_W-1:0]       undo_cnt_reg, undo_cnt_next;
    logic [CNT_W-1:0]       redo_cnt_reg, redo_cnt_next;

    status_t                status_reg, status_next;
    logic [TOKEN_WIDTH-1:0] tok_reg, tok_next;

    logic [CNT_W-1:0]       undo_top, redo_top;
    logic                   undo_we, redo_we;
    logic [ADDR_W-1:0]      undo_wa, redo_wa;
    logic [TOKEN_WIDTH-1:0] undo_wd, redo_wd;
    logic [TW_W-1:0]        value_wide, tok_wide;
    logic [CW_W-1:0]        undo_wide, redo_wide;

    assign value_wide = TW_W'(in_value);
    assign undo_top   = undo_cnt_reg - CNT_ONE;
    assign redo_top   = redo_cnt_reg - CNT_ONE;
    assign undo_wa    = undo_cnt_reg[ADDR_W-1:0];
    assign redo_wa    = redo_cnt_reg[ADDR_W-1:0];

    always_comb begin
        undo_cnt_next = undo_cnt_reg;
        redo_cnt_next = redo_cnt_reg;
        status_next   = ST_DONE;
        tok_next      = '0;
        undo_we       = 1'b0;
        redo_we       = 1'b0;
        undo_wd       = value_reg;
        redo_wd       = undo_rd_reg;
        case (mode_reg)
            MODE_RECORD: begin
                tok_next = value_reg;
                if (undo_cnt_reg == CNT_FULL) begin
                    status_next = ST_FULL;
                end else begin
                    undo_we       = 1'b1;
                    undo_cnt_next = undo_cnt_reg + CNT_ONE;
                end
            end
            MODE_UNDO: begin
                if (undo_cnt_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    // pop always; the token is lost if redo is full
                    undo_cnt_next = undo_top;
                    tok_next      = undo_rd_reg;
                    if (redo_cnt_reg == CNT_FULL) begin
                        status_next = ST_FULL;
                    end else begin
                        redo_we       = 1'b1;
                        redo_cnt_next = redo_cnt_reg + CNT_ONE;
                    end
                end
            end
            MODE_REDO: begin
                undo_wd = redo_rd_reg;
                if (redo_cnt_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    redo_cnt_next = redo_top;
                    tok_next      = redo_rd_reg;
                    if (undo_cnt_reg == CNT_FULL) begin
                        status_next = ST_FULL;
                    end else begin
                        undo_we       = 1'b1;
                        undo_cnt_next = undo_cnt_reg + CNT_ONE;
                    end
                end
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    // stack memories: one write and one registered read per cycle each
    always_ff @(posedge aclk) begin
        if (cmd.exec && undo_we) begin
            undo_mem[undo_wa] <= undo_wd;
        end
        if (cmd.load) begin
            undo_rd_reg <= undo_mem[undo_top[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && redo_we) begin
            redo_mem[redo_wa] <= redo_wd;
        end
        if (cmd.load) begin
            redo_rd_reg <= redo_mem[redo_top[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            value_reg <= value_wide[TOKEN_WIDTH-1:0];
        end
        if (cmd.exec) begin
            status_reg <= status_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            undo_cnt_reg <= '0;
            redo_cnt_reg <= '0;
        end else if (cmd.exec) begin
            undo_cnt_reg <= undo_cnt_next;
            redo_cnt_reg <= redo_cnt_next;
        end
    end

    assign tok_wide       = TW_W'(tok_reg);
    assign undo_wide      = CW_W'(undo_cnt_reg);
    assign redo_wide      = CW_W'(redo_cnt_reg);
    assign out_status     = status_reg;
    assign out_value      = tok_wide[VALUE_W-1:0];
    assign out_undo_depth = undo_wide[DEPTH_W-1:0];
    assign out_redo_depth = redo_wide[DEPTH_W-1:0];

endmodule

/* rtl/core/undo_redo_stack_pair.sv */
// Top level of the undo/redo two-stack edit history.
//
//   Channel  Dir  tdata                                       tuser
//   s_axis   in   entry_value[31:0]                           mode[1:0]
//   m_axis   out  moved_value[31:0], undo_depth, redo_depth   status[1:0]
//
// A word is accepted in ST_IDLE, which issues the registered read of both
// stack tops; ST_EXEC then writes the target memory and loads the result
// register, and only then is the next word taken. A waiting result does not
// block the next accept; ST_EXEC holds while the result register is still full.
// aresetn is synchronous; it clears both depths and the handshake state.
module undo_redo_stack_pair #(
    parameter int STACK_DEPTH = 128,
    parameter int TOKEN_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // entry_value[31:0]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // moved_value[31:0], undo_depth[39:32],
                                        // redo_depth[47:40]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import urs_pkg::*;

    urs_cmd_t            cmd;
    status_t             status;
    logic [VALUE_W-1:0]  moved_value;
    logic [DEPTH_W-1:0]  undo_depth;
    logic [DEPTH_W-1:0]  redo_depth;

    urs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    urs_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_mode        (s_axis_tuser),
        .in_value       (s_axis_tdata),
        .out_status     (status),
        .out_value      (moved_value),
        .out_undo_depth (undo_depth),
        .out_redo_depth (redo_depth)
    );

    assign m_axis_tdata = {redo_depth, undo_depth, moved_value};
    assign m_axis_tuser = status;

endmodule

/* tb/undo_redo_stack_pair_test.sv */
// Self-checking stream testbench for the undo/redo two-stack edit history.
`timescale 1ns / 1ps

module undo_redo_stack_pair_test;
    import urs_pkg::*;

    localparam int    HISTORY_DEPTH = 128;
    localparam int    WORD_TARGET   = 1450;
    localparam mode_t MODE_UNUSED   = 2'd3;

    typedef struct {
        status_t     status;
        logic [31:0] moved_value;
        logic [7:0]  undo_depth;
        logic [7:0]  redo_depth;
    } history_result_t;

    class history_scoreboard;
        logic [31:0]     undo_tokens[HISTORY_DEPTH];
        logic [31:0]     redo_tokens[HISTORY_DEPTH];
        int              undo_level = 0;
        int              redo_level = 0;
        history_result_t pending[$];
        int              errors = 0;

        // Predict the result of one accepted command word.
        function void note_command(mode_t mode, logic [31:0] value);
            history_result_t r;
            r.status      = ST_DONE;
            r.moved_value = '0;
            case (mode)
                MODE_RECORD: begin
                    r.moved_value = value;
                    if (undo_level == HISTORY_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        undo_tokens[undo_level] = value;
                        undo_level++;
                    end
                end
                MODE_UNDO: begin
                    if (undo_level == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        undo_level--;
                        r.moved_value = undo_tokens[undo_level];
                        // a full redo stack loses the popped token
                        if (redo_level == HISTORY_DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            redo_tokens[redo_level] = r.moved_value;
                            redo_level++;
                        end
                    end
                end
                MODE_REDO: begin
                    if (redo_level == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        redo_level--;
                        r.moved_value = redo_tokens[redo_level];
                        if (undo_level == HISTORY_DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            undo_tokens[undo_level] = r.moved_value;
                            undo_level++;
                        end
                    end
                end
                default: ;
            endcase
            r.undo_depth = 8'(undo_level);
            r.redo_depth = 8'(redo_level);
            pending.push_back(r);
        endfunction

        function void check_result(status_t status, logic [47:0] data);
            history_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result word: status %0d, data 0x%012h", status, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (data[31:0] !== want.moved_value) begin
                $error("moved_value: expected 0x%08h, actual 0x%08h",
                       want.moved_value, data[31:0]);
                errors++;
            end
            if (data[39:32] !== want.undo_depth) begin
                $error("undo_depth: expected %0d, actual %0d", want.undo_depth, data[39:32]);
                errors++;
            end
            if (data[47:40] !== want.redo_depth) begin
                $error("redo_depth: expected %0d, actual %0d", want.redo_depth, data[47:40]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    history_scoreboard board = new();
    bit                no_idle    = 1'b0;
    int                sent_words = 0;

    undo_redo_stack_pair u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_cycles();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_command(input mode_t mode, input logic [31:0] value);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_command(mode, value);
        sent_words++;
    endtask

    task automatic send_burst(input mode_t mode, input int count);
        repeat (count) send_command(mode, $urandom);
    endtask

    // Result side: check every accepted word, then pick the next ready.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready)
                board.check_result(m_axis_tuser, m_axis_tdata);
            if (!aresetn) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = idle_cycles();
            end
        end
    end

    initial begin
        int    phase;
        int    len;
        mode_t pick;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty stacks, extreme tokens, unused mode, round trip.
        send_command(MODE_UNDO, 32'hFFFF_FFFF);
        send_command(MODE_REDO, 32'hFFFF_FFFF);
        send_command(MODE_RECORD, 32'h0000_0000);
        send_command(MODE_RECORD, 32'hFFFF_FFFF);
        send_command(MODE_RECORD, 32'h5A5A_A5A5);
        send_command(MODE_UNUSED, 32'hFFFF_FFFF);
        send_command(MODE_UNDO, 32'h0);
        send_command(MODE_UNDO, 32'hFFFF_FFFF);
        send_command(MODE_UNDO, 32'h0);
        send_command(MODE_UNDO, 32'h0);
        send_command(MODE_REDO, 32'h0);
        send_command(MODE_REDO, 32'hFFFF_FFFF);
        send_command(MODE_REDO, 32'h0);
        send_command(MODE_REDO, 32'h0);
        send_command(MODE_RECORD, 32'h0000_0001);
        send_command(MODE_UNUSED, 32'h0);
        send_command(MODE_RECORD, 32'h8000_0000);

        // Overfill undo, drain into a full redo, lose tokens on undo into it,
        // then refill undo and lose tokens on redo into it.
        send_burst(MODE_RECORD, HISTORY_DEPTH + 2);
        send_burst(MODE_UNDO, HISTORY_DEPTH + 4);
        send_burst(MODE_RECORD, 4);
        send_burst(MODE_UNDO, 3);
        send_burst(MODE_RECORD, HISTORY_DEPTH + 4);
        send_burst(MODE_REDO, 3);

        while (sent_words < WORD_TARGET) begin
            no_idle = ($urandom_range(0, 3) == 0);
            phase   = $urandom_range(0, 9);
            case (phase)
                0, 1, 2: send_burst(MODE_RECORD, $urandom_range(1, 150));
                3, 4:    send_burst(MODE_UNDO, $urandom_range(1, 150));
                5, 6:    send_burst(MODE_REDO, $urandom_range(1, 150));
                default: begin
                    len = $urandom_range(1, 40);
                    repeat (len) begin
                        pick = mode_t'($urandom_range(0, 3));
                        send_command(pick, $urandom);
                    end
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        // let any stray word show up
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
